[src/mrr_pkg.sv]
// ============================================================================
// mrr_pkg
// Shared types and constants for the matrix ring rotation block.
// ============================================================================
package mrr_pkg;

    // Fixed field widths of the item, result and configuration channels.
    localparam int ELEM_W      = 32;
    localparam int DIM_W       = 7;
    localparam int CFG_INDEX_W = 4;

    // Defaults for the top-level parameters.
    localparam int MAX_ROWS_DEFAULT   = 64;
    localparam int MAX_COLS_DEFAULT   = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 4'd1;

    // Item commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Result buffer in the back part.
    localparam int RES_DEPTH = 2;
    localparam int RES_CNT_W = 2;

    typedef struct packed {
        logic                     cmd;
        logic signed [ELEM_W-1:0] element_value;
    } item_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] rotated_value;
        logic                     last_element;
    } result_t;

    // Control part of one queued memory operation.
    typedef struct packed {
        logic is_read;
        logic last;
    } op_ctl_t;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic                 pend;
        logic [RES_CNT_W-1:0] res_count;
    } back_status_t;

endpackage

[src/matrix_ring_rotate_top.sv]
// ============================================================================
// matrix_ring_rotate_top
// Rotates every concentric ring of a stored matrix clockwise by one.
// ============================================================================
//
// Usage:
// Set row_count (index 0) and column_count (index 1) on the configuration
// port; either write restarts loading and reading at element zero. Then send
// load items (cmd 0) with the elements in row-major order, and read items
// (cmd 1), each of which returns the next rotated element in row-major order,
// with last_element set on the final one. Loads return nothing.
// The item channel takes one item per cycle unless stalled: each item is a
// single access to the one-write, one-read port matrix store, which sets the
// rate. Item stall rises only when the four-entry command queue is full,
// which happens when the result receiver stalls and the two-entry result
// buffer has filled up. Reset sets both sizes to 1 and both positions to
// zero; the store has no clearing pass and an element must be loaded before
// it is read.
//
module matrix_ring_rotate_top import mrr_pkg::*; #(
    parameter int MAX_ROWS   = MAX_ROWS_DEFAULT,
    parameter int MAX_COLS   = MAX_COLS_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CTL_W = $bits(op_ctl_t);
    localparam int EW    = CTL_W + AW + DATA_WIDTH;

    logic                  cmd_push, q_pop;
    op_ctl_t               cmd_ctl, head_ctl;
    logic [AW-1:0]         cmd_addr, head_addr;
    logic [DATA_WIDTH-1:0] cmd_data, head_data;
    logic [EW-1:0]         push_entry, head_entry;
    queue_status_t         q_status;
    back_status_t          bk_status;

    mrr_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (q_status.full),
        .cmd_push   (cmd_push),
        .cmd_ctl    (cmd_ctl),
        .cmd_addr   (cmd_addr),
        .cmd_data   (cmd_data)
    );

    assign push_entry = {cmd_ctl, cmd_addr, cmd_data};

    mrr_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .head_data (head_entry),
        .status    (q_status)
    );

    assign {head_ctl, head_addr, head_data} = head_entry;

    mrr_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_status.empty),
        .head_ctl     (head_ctl),
        .head_addr    (head_addr),
        .head_data    (head_data),
        .head_pop     (q_pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .status       (bk_status)
    );

`ifndef SYNTHESIS
    // The command queue never holds more operations than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("command queue over capacity");

    // The back part only takes operations that are present in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty command queue");

    // A read in flight in the store always has a result slot waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.pend |-> (bk_status.res_count < RES_CNT_W'(RES_DEPTH)
                            || !result_stall))
        else $error("read result has no buffer slot");
`endif

endmodule

[src/mrr_ram.sv]
// ============================================================================
// mrr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module mrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/mrr_queue.sv]
// ============================================================================
// mrr_queue
// Short FIFO that carries memory operations from the front to the back part.
// ============================================================================
module mrr_queue import mrr_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0]       mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

[src/mrr_front.sv]
// ============================================================================
// mrr_front
// Accepts items, holds the size registers and positions, and turns each item
// into one memory write or one memory read with its source address.
// ============================================================================
module mrr_front import mrr_pkg::*; #(
    parameter int MAX_ROWS   = MAX_ROWS_DEFAULT,
    parameter int MAX_COLS   = MAX_COLS_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
    localparam int AW        = $clog2(MAX_ROWS * MAX_COLS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic                   queue_full,
    output logic                   cmd_push,
    output op_ctl_t                cmd_ctl,
    output logic [AW-1:0]          cmd_addr,
    output logic [DATA_WIDTH-1:0]  cmd_data
);

    localparam int TW = 2 * DIM_W;
    localparam int CW = (AW + 1 > TW) ? AW + 1 : TW;
    localparam int XW = (DATA_WIDTH > ELEM_W) ? DATA_WIDTH : ELEM_W;

    function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [DIM_W-1:0] row_count_reg, row_count_next;
    logic [DIM_W-1:0] column_count_reg, column_count_next;
    logic [AW-1:0]    load_pos_reg, load_pos_next;
    logic [AW-1:0]    read_pos_reg, read_pos_next;
    logic [DIM_W-1:0] read_row_reg, read_row_next;
    logic [DIM_W-1:0] read_col_reg, read_col_next;

    logic [DIM_W-1:0] rows, cols;
    logic [TW-1:0]    total;
    logic [CW-1:0]    load_step, read_step;
    logic             load_wrap, read_last;
    logic [DIM_W-1:0] dist_bottom, dist_right, ring, rings;
    logic [AW-1:0]    cols_a, src_addr;
    logic [XW-1:0]    elem_wide;
    logic             accept;

    // Sizes out of range act as the nearest legal size.
    always_comb
    begin
        rows = row_count_reg;
        if (row_count_reg == '0)
        begin
            rows = DIM_W'(1);
        end
        else if (row_count_reg > MAX_ROWS)
        begin
            rows = DIM_W'(MAX_ROWS);
        end
        cols = column_count_reg;
        if (column_count_reg == '0)
        begin
            cols = DIM_W'(1);
        end
        else if (column_count_reg > MAX_COLS)
        begin
            cols = DIM_W'(MAX_COLS);
        end
    end

    assign total     = TW'(rows) * TW'(cols);
    assign load_step = CW'(load_pos_reg) + CW'(1);
    assign read_step = CW'(read_pos_reg) + CW'(1);
    assign load_wrap = (load_step >= CW'(total));
    assign read_last = (read_step >= CW'(total));

    assign dist_bottom = rows - DIM_W'(1) - read_row_reg;
    assign dist_right  = cols - DIM_W'(1) - read_col_reg;
    assign ring        = min_dim(min_dim(read_row_reg, read_col_reg),
                                 min_dim(dist_bottom, dist_right));
    assign rings       = min_dim(rows, cols) >> 1;
    assign cols_a      = AW'(cols);

    // Each ring position takes the element that precedes it clockwise; the
    // middle line of an odd size is not on any ring and reads itself.
    always_comb
    begin
        if (ring >= rings)
        begin
            src_addr = read_pos_reg;
        end
        else if (read_row_reg == ring && read_col_reg > ring)
        begin
            src_addr = read_pos_reg - AW'(1);
        end
        else if (dist_right == ring && read_row_reg > ring)
        begin
            src_addr = read_pos_reg - cols_a;
        end
        else if (dist_bottom == ring && dist_right > ring)
        begin
            src_addr = read_pos_reg + AW'(1);
        end
        else
        begin
            src_addr = read_pos_reg + cols_a;
        end
    end

    assign elem_wide  = XW'($unsigned(item.element_value));
    assign accept     = item_valid && !queue_full;
    assign item_stall = queue_full;
    assign cfg_ready  = 1'b1;

    assign cmd_push        = accept;
    assign cmd_ctl.is_read = (item.cmd == CMD_READ);
    assign cmd_ctl.last    = (item.cmd == CMD_READ) && read_last;
    assign cmd_addr        = (item.cmd == CMD_READ) ? src_addr : load_pos_reg;
    assign cmd_data        = elem_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        load_pos_next     = load_pos_reg;
        read_pos_next     = read_pos_reg;
        read_row_next     = read_row_reg;
        read_col_next     = read_col_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_COUNT:
                begin
                    row_count_next = cfg_data;
                    load_pos_next  = '0;
                    read_pos_next  = '0;
                    read_row_next  = '0;
                    read_col_next  = '0;
                end
                REG_COLUMN_COUNT:
                begin
                    column_count_next = cfg_data;
                    load_pos_next     = '0;
                    read_pos_next     = '0;
                    read_row_next     = '0;
                    read_col_next     = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && item.cmd == CMD_LOAD)
        begin
            load_pos_next = load_wrap ? '0 : load_step[AW-1:0];
        end
        else if (accept)
        begin
            read_pos_next = read_last ? '0 : read_step[AW-1:0];
            if (read_col_reg == cols - DIM_W'(1))
            begin
                read_col_next = '0;
                read_row_next = read_last ? '0 : read_row_reg + DIM_W'(1);
            end
            else
            begin
                read_col_next = read_col_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_W'(1);
            column_count_reg <= DIM_W'(1);
            load_pos_reg     <= '0;
            read_pos_reg     <= '0;
            read_row_reg     <= '0;
            read_col_reg     <= '0;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            load_pos_reg     <= load_pos_next;
            read_pos_reg     <= read_pos_next;
            read_row_reg     <= read_row_next;
            read_col_reg     <= read_col_next;
        end
    end

endmodule

[src/mrr_back.sv]
// ============================================================================
// mrr_back
// Executes queued memory operations on the matrix store and buffers the
// read results toward the result channel.
// ============================================================================
module mrr_back import mrr_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
    parameter int DEPTH      = MAX_ROWS_DEFAULT * MAX_COLS_DEFAULT,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  op_ctl_t               head_ctl,
    input  logic [AW-1:0]         head_addr,
    input  logic [DATA_WIDTH-1:0] head_data,
    output logic                  head_pop,
    input  logic                  result_stall,
    output logic                  result_valid,
    output result_t               result,
    output back_status_t          status
);

    localparam int XW = (DATA_WIDTH > ELEM_W) ? DATA_WIDTH : ELEM_W;

    result_t              res_mem_reg [RES_DEPTH];
    logic                 res_wptr_reg, res_wptr_next;
    logic                 res_rptr_reg, res_rptr_next;
    logic [RES_CNT_W-1:0] res_count_reg, res_count_next;
    logic                 pend_reg, pend_last_reg;

    logic                 out_pop, can_read, ram_we, ram_re;
    logic [RES_CNT_W:0]   room_used;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [XW-1:0]        rdata_wide;
    result_t              res_in;

    mrr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_addr),
        .wdata (head_data),
        .re    (ram_re),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    assign out_pop = (res_count_reg != '0) && !result_stall;

    // A read is started only if its result is sure to find a buffer slot,
    // counting the read whose data is still coming out of the store.
    assign room_used = (RES_CNT_W + 1)'(res_count_reg) - (RES_CNT_W + 1)'(out_pop)
                     + (RES_CNT_W + 1)'(pend_reg);
    assign can_read  = (room_used < (RES_CNT_W + 1)'(RES_DEPTH));

    assign head_pop = head_valid && (!head_ctl.is_read || can_read);
    assign ram_we   = head_pop && !head_ctl.is_read;
    assign ram_re   = head_pop && head_ctl.is_read;

    assign rdata_wide           = XW'(ram_rdata);
    assign res_in.rotated_value = rdata_wide[ELEM_W-1:0];
    assign res_in.last_element  = pend_last_reg;

    always_comb
    begin
        res_wptr_next  = res_wptr_reg;
        res_rptr_next  = res_rptr_reg;
        res_count_next = res_count_reg;
        if (pend_reg)
        begin
            res_wptr_next = ~res_wptr_reg;
        end
        if (out_pop)
        begin
            res_rptr_next = ~res_rptr_reg;
        end
        if (pend_reg && !out_pop)
        begin
            res_count_next = res_count_reg + RES_CNT_W'(1);
        end
        else if (out_pop && !pend_reg)
        begin
            res_count_next = res_count_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wptr_reg  <= 1'b0;
            res_rptr_reg  <= 1'b0;
            res_count_reg <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            res_wptr_reg  <= res_wptr_next;
            res_rptr_reg  <= res_rptr_next;
            res_count_reg <= res_count_next;
            pend_reg      <= ram_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            pend_last_reg <= head_ctl.last;
        end
        if (pend_reg)
        begin
            res_mem_reg[res_wptr_reg] <= res_in;
        end
    end

    assign result_valid     = (res_count_reg != '0);
    assign result           = res_mem_reg[res_rptr_reg];
    assign status.pend      = pend_reg;
    assign status.res_count = res_count_reg;

endmodule

[test/matrix_ring_rotate_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// matrix_ring_rotate_top_test
// Self-checking bench for the ring rotation block. Loads matrices of many
// sizes, reads back the rotated elements and checks each one against a
// scoreboard that rotates its own copy of the matrix, under several idling
// and stalling patterns on the item and result channels.
// ============================================================================
module matrix_ring_rotate_top_test;
    import mrr_pkg::*;

    localparam int MAX_R       = MAX_ROWS_DEFAULT;
    localparam int MAX_C       = MAX_COLS_DEFAULT;
    localparam int STORE_DEPTH = MAX_R * MAX_C;

    class rotation_scoreboard;
        logic signed [ELEM_W-1:0] store_mem [STORE_DEPTH];
        bit                       written_mem [STORE_DEPTH];
        int                       rows_reg;
        int                       cols_reg;
        int                       load_pos;
        int                       read_pos;
        result_t                  rotated_q[$];
        int                       errors;

        function new();
            rows_reg = 1;
            cols_reg = 1;
            load_pos = 0;
            read_pos = 0;
            errors   = 0;
            foreach (written_mem[k])
                written_mem[k] = 1'b0;
        endfunction

        function int clamp(int v, int maxv);
            if (v < 1)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function int min2(int a, int b);
            return (a < b) ? a : b;
        endfunction

        function int total_elements();
            return clamp(rows_reg, MAX_R) * clamp(cols_reg, MAX_C);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [DIM_W-1:0] data);
            if (index == REG_ROW_COUNT)
                rows_reg = int'(data);
            else if (index == REG_COLUMN_COUNT)
                cols_reg = int'(data);
            else
                return;
            load_pos = 0;
            read_pos = 0;
        endfunction

        // Address of the element that lands on the next read position.
        function int source_addr();
            int rows, cols, total, pos, i, j, ring, rings, si, sj;
            rows  = clamp(rows_reg, MAX_R);
            cols  = clamp(cols_reg, MAX_C);
            total = rows * cols;
            pos   = (read_pos < total) ? read_pos : 0;
            i     = pos / cols;
            j     = pos % cols;
            ring  = min2(min2(i, j), min2(rows - 1 - i, cols - 1 - j));
            rings = min2(rows, cols) / 2;
            si    = i;
            sj    = j;
            if (ring < rings)
            begin
                if (i == ring && j > ring)
                    sj = j - 1;
                else if (j == cols - 1 - ring && i > ring)
                    si = i - 1;
                else if (i == rows - 1 - ring && j < cols - 1 - ring)
                    sj = j + 1;
                else
                    si = i + 1;
            end
            return si * cols + sj;
        endfunction

        function bit read_source_ready();
            return written_mem[source_addr()];
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction

        function void note_item(item_t it);
            int      total, pos;
            result_t exp;
            total = total_elements();
            if (it.cmd == CMD_LOAD)
            begin
                pos = (load_pos < total) ? load_pos : 0;
                store_mem[pos]   = it.element_value;
                written_mem[pos] = 1'b1;
                pos++;
                load_pos = (pos >= total) ? 0 : pos;
            end
            else
            begin
                pos = (read_pos < total) ? read_pos : 0;
                exp.rotated_value = store_mem[source_addr()];
                exp.last_element  = (pos + 1 == total);
                rotated_q = {rotated_q, exp};
                pos++;
                read_pos = (pos >= total) ? 0 : pos;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (rotated_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0d last %0b",
                         $time, got.rotated_value, got.last_element);
                errors++;
                return;
            end
            exp = rotated_q.pop_front();
            if (got.rotated_value !== exp.rotated_value)
            begin
                $display("%0t: rotated_value mismatch, expected %0d, actual %0d",
                         $time, exp.rotated_value, got.rotated_value);
                errors++;
            end
            if (got.last_element !== exp.last_element)
            begin
                $display("%0t: last_element mismatch, expected %0b, actual %0b",
                         $time, exp.last_element, got.last_element);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [DIM_W-1:0]       cfg_data     = '0;

    rotation_scoreboard     sb;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    int                     item_count     = 0;
    logic [CFG_INDEX_W-1:0] cfg_idx_q[$];
    logic [DIM_W-1:0]       cfg_data_q[$];

    matrix_ring_rotate_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(4))
                0: return 7'd0;
                1: return 7'd1;
                2: return 7'd64;
                3: return 7'd65;
                default: return 7'd127;
            endcase
        end
        return DIM_W'($urandom_range(1, 8));
    endfunction

    task automatic send_cmd(input logic cmd, input logic [ELEM_W-1:0] value);
        item_t it;
        int    gap;
        it.cmd           = cmd;
        it.element_value = value;
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        sb.note_item(it);
        item_count++;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A read is sent only when the element it rotates in was loaded already.
    task automatic issue(input bit want_read);
        if (want_read && sb.read_source_ready())
            send_cmd(CMD_READ, random_element());
        else
            send_cmd(CMD_LOAD, random_element());
    endtask

    task automatic queue_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [DIM_W-1:0] data);
        cfg_idx_q  = {cfg_idx_q, index};
        cfg_data_q = {cfg_data_q, data};
    endtask

    task automatic program_registers();
        logic [CFG_INDEX_W-1:0] index;
        logic [DIM_W-1:0]       data;
        if (cfg_idx_q.size() == 0)
            return;
        cfg_valid <= 1'b1;
        while (cfg_idx_q.size() != 0)
        begin
            index = cfg_idx_q.pop_front();
            data  = cfg_data_q.pop_front();
            cfg_index <= index;
            cfg_data  <= data;
            do @(posedge clk); while (!cfg_ready);
            sb.set_register(index, data);
        end
        cfg_valid <= 1'b0;
    endtask

    // Loads cause no result, so an extra wait after the results covers one still in flight.
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int phase, total, reps, n, p_read;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size is one by one: the element comes back unchanged.
        send_cmd(CMD_LOAD, 32'h7FFF_FFFF);
        send_cmd(CMD_READ, 32'h0000_0000);
        send_cmd(CMD_LOAD, 32'h8000_0000);
        send_cmd(CMD_READ, 32'hFFFF_FFFF);
        item_valid <= 1'b0;

        wait_idle();
        queue_register(REG_ROW_COUNT, 7'd2);
        queue_register(REG_COLUMN_COUNT, 7'd2);
        program_registers();
        send_cmd(CMD_LOAD, 32'h8000_0000);
        send_cmd(CMD_LOAD, 32'h7FFF_FFFF);
        send_cmd(CMD_LOAD, 32'h0000_0000);
        send_cmd(CMD_LOAD, 32'hFFFF_FFFF);
        repeat (4) send_cmd(CMD_READ, 32'h0000_0000);
        item_valid <= 1'b0;

        // Sizes of zero act as one.
        wait_idle();
        queue_register(REG_ROW_COUNT, 7'd0);
        queue_register(REG_COLUMN_COUNT, 7'd0);
        queue_register(4'hF, 7'h7F);
        program_registers();
        send_cmd(CMD_LOAD, 32'h1234_5678);
        send_cmd(CMD_READ, 32'h0000_0000);
        item_valid <= 1'b0;

        // A single row has no ring and stays unchanged.
        wait_idle();
        queue_register(REG_ROW_COUNT, 7'd1);
        queue_register(REG_COLUMN_COUNT, 7'd3);
        program_registers();
        repeat (3) send_cmd(CMD_LOAD, random_element());
        repeat (3) send_cmd(CMD_READ, random_element());
        item_valid <= 1'b0;

        item_count = 0;
        phase = 0;
        while (item_count < 1000)
        begin
            case (phase % 5)
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            wait_idle();
            if (phase == 2)
            begin
                queue_register(REG_ROW_COUNT, 7'd127);
                queue_register(REG_COLUMN_COUNT, 7'd64);
            end
            else
            begin
                case ($urandom_range(3))
                    0: queue_register(REG_ROW_COUNT, pick_size());
                    1: queue_register(REG_COLUMN_COUNT, pick_size());
                    default:
                    begin
                        queue_register(REG_ROW_COUNT, pick_size());
                        queue_register(REG_COLUMN_COUNT, pick_size());
                    end
                endcase
                if ($urandom_range(99) < 15)
                    queue_register(CFG_INDEX_W'($urandom_range(2, 15)),
                                   DIM_W'($urandom_range(0, 127)));
            end
            program_registers();
            total = sb.total_elements();
            if (total <= 48 && $urandom_range(3) != 0)
            begin
                // Whole matrix in, then the rotated matrix out once or twice.
                reps = $urandom_range(1, 2);
                repeat (total) issue(1'b0);
                repeat (total * reps) issue(1'b1);
            end
            else
            begin
                n = 2 * total + 4;
                if (n > 300)
                    n = 300;
                p_read = $urandom_range(20, 80);
                repeat (n) issue($urandom_range(99) < p_read);
            end
            item_valid <= 1'b0;
            phase++;
        end

        wait_idle();
        repeat (12) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
